/* src/isle_pkg.sv */
// Shared types and constants for the indexed sequence list engine.
// No dependencies; imported by the top level.
package isle_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 7;
  localparam int CNT_OW = 7;

  // found_index when the value is absent (-1 in 7 bits)
  localparam logic [IDX_W-1:0] IDX_NONE = '1;

  // request codes; the two unused codes fall to the default arm
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_READ     = 3'd2,
    ACT_WRITE    = 3'd3,
    ACT_FIND     = 3'd4,
    ACT_CONTAINS = 3'd5
  } act_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

/* src/isle_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module isle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/indexed_sequence_list_engine_top.sv */
// Indexed sequence list engine: ordered list of signed words in a RAM.
// Depends on isle_pkg and isle_ram.
//
// Usage
//   Input channel (in_valid / in_stall): one request word carries an action,
//   a position and a value. A word is taken when in_valid is high and
//   in_stall is low. in_stall is high whenever the sequencer is busy.
//   Output channel (out_valid / out_stall): one result word per request,
//   held in an output register until out_stall is low.
// Steps from the accepted request to out_valid (each result passes DONE):
//   write, refused or unknown request, search on an empty list: to DONE
//   read: FETCH, then DONE
//   insert at p: SHIFT moves the count - p words at and above p, COMMIT
//   remove at p: FETCH, SHIFT moves the count - p - 1 words above p, COMMIT
//   find / contains: SCAN compares words in order (first hit stops it)
// Requests are taken one at a time; the single RAM read and write port
// moves or compares one word per cycle. A new request is taken while the
// previous result still waits in the output register.
// Reset (rst_n low, synchronous) empties the list; the RAM contents are not
// cleared, and words beyond the fill count are never used.
// If the receiver stalls, a finished result waits in the DONE state.
module indexed_sequence_list_engine_top #(
  parameter int CAPACITY = isle_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [isle_pkg::ACT_W-1:0]        in_action,
  input  logic [isle_pkg::POS_W-1:0]        in_position,
  input  logic signed [isle_pkg::VAL_W-1:0] in_item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic signed [isle_pkg::VAL_W-1:0] out_result_value,
  output logic signed [isle_pkg::IDX_W-1:0] out_found_index,
  output logic [isle_pkg::CNT_OW-1:0]       out_entry_count
);
  import isle_pkg::*;

  localparam int AW = $clog2(CAPACITY);          // RAM address
  localparam int CW = $clog2(CAPACITY + 1);      // count 0..CAPACITY
  localparam int XW = (CW > POS_W) ? CW : POS_W; // compare width

  state_t           state_r, state_nxt;
  act_t             op_r, op_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // walk pointers shared by shift and scan
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    rd_left_r, rd_left_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;

  // result being built
  logic             res_ok_r, res_ok_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [CNT_OW-1:0] out_cnt_r, out_cnt_nxt;

  // RAM ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic          accept;
  logic [XW-1:0] pos_x, cnt_x, cap_x;
  logic          step_up;
  logic [AW-1:0] ptr_step;
  logic [XW-1:0] hit_x;
  logic [XW-1:0] cnt_out_x;
  logic          hit;

  isle_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign pos_x = XW'(in_position);
  assign cnt_x = XW'(count_r);
  assign cap_x = XW'(CAPACITY);

  // one pointer stepper: insert walks down, remove and scan walk up
  assign step_up  = (op_r != ACT_INSERT);
  assign ptr_step = step_up ? (rd_ptr_r + AW'(1)) : (rd_ptr_r - AW'(1));

  assign hit       = pend_r && (ram_rdata == val_r);
  assign hit_x     = XW'(wr_ptr_r);
  assign cnt_out_x = XW'(count_nxt);

  // the IDLE cycle reads at the requested position, later states walk
  assign ram_raddr = (state_r == S_IDLE) ? AW'(pos_x) : rd_ptr_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_left_nxt   = rd_left_r;
    pend_nxt      = 1'b0;
    wr_ptr_nxt    = wr_ptr_r;
    res_ok_nxt    = res_ok_r;
    res_val_nxt   = res_val_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = val_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = act_t'(in_action);
          pos_nxt     = AW'(pos_x);
          val_nxt     = in_item_value;
          res_ok_nxt  = 1'b0;
          res_val_nxt = '0;
          res_idx_nxt = IDX_NONE;
          state_nxt   = S_DONE;
          case (act_t'(in_action))
            ACT_INSERT: begin
              if (cnt_x < cap_x && pos_x <= cnt_x) begin
                res_ok_nxt  = 1'b1;
                rd_ptr_nxt  = AW'(count_r - CW'(1));
                rd_left_nxt = CW'(cnt_x - pos_x);
                state_nxt   = S_SHIFT;
              end
            end
            ACT_REMOVE, ACT_READ: begin
              if (pos_x < cnt_x) begin
                res_ok_nxt = 1'b1;
                state_nxt  = S_FETCH;
              end
            end
            ACT_WRITE: begin
              if (pos_x < cnt_x) begin
                res_ok_nxt = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_x);
                ram_wdata  = in_item_value;
              end
            end
            ACT_FIND, ACT_CONTAINS: begin
              if (count_r != '0) begin
                rd_ptr_nxt  = '0;
                rd_left_nxt = count_r;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FETCH: begin
        res_val_nxt = ram_rdata;
        if (op_r == ACT_REMOVE) begin
          rd_ptr_nxt  = pos_r + AW'(1);
          rd_left_nxt = count_r - CW'(pos_r) - CW'(1);
          state_nxt   = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        // write back the word fetched last cycle one place over
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_r;
          ram_wdata = ram_rdata;
        end
        if (rd_left_r != '0) begin
          pend_nxt    = 1'b1;
          wr_ptr_nxt  = step_up ? (rd_ptr_r - AW'(1)) : (rd_ptr_r + AW'(1));
          rd_ptr_nxt  = ptr_step;
          rd_left_nxt = rd_left_r - CW'(1);
        end else begin
          state_nxt = S_COMMIT;
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_ok_nxt  = 1'b1;
          res_idx_nxt = hit_x[IDX_W-1:0];
          state_nxt   = S_DONE;
        end else if (rd_left_r != '0) begin
          pend_nxt    = 1'b1;
          wr_ptr_nxt  = rd_ptr_r;
          rd_ptr_nxt  = ptr_step;
          rd_left_nxt = rd_left_r - CW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_COMMIT: begin
        if (op_r == ACT_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = val_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_val_nxt   = res_val_r;
          out_idx_nxt   = res_idx_r;
          out_cnt_nxt   = cnt_out_x[CNT_OW-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    rd_left_r <= rd_left_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    res_ok_r  <= res_ok_nxt;
    res_val_r <= res_val_nxt;
    res_idx_r <= res_idx_nxt;
    out_ok_r  <= out_ok_nxt;
    out_val_r <= out_val_nxt;
    out_idx_r <= out_idx_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_result_value = out_val_r;
  assign out_found_index  = out_idx_r;
  assign out_entry_count  = out_cnt_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= cap_x)
    else $error("list count above capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word loaded outside DONE");

  a_commit_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |=> (count_r != $past(count_r)))
    else $error("commit left count unchanged");

  a_scan_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_left_r <= count_r))
    else $error("scan walks past the fill count");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT || state_r == S_SCAN) |-> in_stall)
    else $error("request taken while walking the list");
`endif

endmodule
